// ----- hw/rtl/utf8_and_escape_key_decoder_defines.svh -----
// Assertion macros shared by the terminal input decoder RTL.
// No dependencies; included by the files that carry assertions.
`ifndef UTF8_AND_ESCAPE_KEY_DECODER_DEFINES_SVH
`define UTF8_AND_ESCAPE_KEY_DECODER_DEFINES_SVH

// same-cycle implication, sampled at the rising clock edge
`define UEK_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed in %m");

// next-cycle implication
`define UEK_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed in %m");

`endif

// ----- hw/rtl/utf8ek_pkg.sv -----
// Types and constants of the UTF-8 / escape key decoder.
// No dependencies; used by the channel interfaces and every RTL module.
`default_nettype none

package utf8ek_pkg;

   typedef enum logic [2:0] {
      MODE_IDLE = 3'd0,
      MODE_UTF8 = 3'd1,
      MODE_ESC  = 3'd2,
      MODE_CSI  = 3'd3,
      MODE_CSI3 = 3'd4,
      MODE_SS3  = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      KIND_CHAR    = 2'd0,
      KIND_KEY     = 2'd1,
      KIND_TIMEOUT = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      KEY_UP     = 3'd0,
      KEY_DOWN   = 3'd1,
      KEY_RIGHT  = 3'd2,
      KEY_LEFT   = 3'd3,
      KEY_HOME   = 3'd4,
      KEY_END    = 3'd5,
      KEY_DELETE = 3'd6
   } keycode_type;

   localparam logic [20:0] REPLACEMENT = 21'h00FFFD;
   localparam logic [7:0]  ESC_BYTE    = 8'h1B;
   localparam logic [7:0]  CSI_BYTE    = 8'h5B;   // '['
   localparam logic [7:0]  SS3_BYTE    = 8'h4F;   // 'O'
   localparam logic [7:0]  CH_A        = 8'h41;
   localparam logic [7:0]  CH_B        = 8'h42;
   localparam logic [7:0]  CH_C        = 8'h43;
   localparam logic [7:0]  CH_D        = 8'h44;
   localparam logic [7:0]  CH_F        = 8'h46;
   localparam logic [7:0]  CH_H        = 8'h48;
   localparam logic [7:0]  CH_3        = 8'h33;
   localparam logic [7:0]  CH_TILDE    = 8'h7E;

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_GAP  = 1'b1;

   typedef struct packed {
      mode_type    mode;
      logic [1:0]  remaining;
      logic [2:0]  exp_len;
      logic [31:0] collected;
   } state_type;

   typedef struct packed {
      kind_type    kind;
      logic [20:0] codepoint;
      logic [2:0]  claim_len;
      logic [31:0] raw_bytes;
      keycode_type key_code;
   } result_type;

endpackage

`default_nettype wire

// ----- hw/rtl/utf8ek_if.sv -----
// Valid/ready channel interfaces for request and response words.
// Depends on utf8ek_pkg.
`default_nettype none

interface utf8ek_req_if import utf8ek_pkg::*; ();
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] data_byte;

   modport source (output valid, output cmd, output data_byte, input ready);
   modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

interface utf8ek_rsp_if import utf8ek_pkg::*; ();
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [20:0] codepoint;
   logic [2:0]  claim_len;
   logic [31:0] raw_bytes;
   logic [2:0]  key_code;

   modport source (output valid, output kind, output codepoint, output claim_len,
                   output raw_bytes, output key_code, input ready);
   modport sink   (input valid, input kind, input codepoint, input claim_len,
                   input raw_bytes, input key_code, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/utf8ek_parse.sv -----
// Parser state register and the single-pass next-state / result logic.
// Depends on utf8ek_pkg and the assertion macro header.
`default_nettype none
`include "utf8_and_escape_key_decoder_defines.svh"

module utf8ek_parse import utf8ek_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic       cmd,
   input  wire logic [7:0] data_byte,
   output logic            emit,
   output result_type      result
);

   state_type state_ff, state_in;
   state_type nxt;

   function automatic result_type char_result(logic [20:0] cp, logic [2:0] cnt,
                                              logic [31:0] raw);
      result_type r;
      r = '{kind: KIND_CHAR, codepoint: cp, claim_len: cnt, raw_bytes: raw,
            key_code: KEY_UP};
      return r;
   endfunction

   function automatic result_type key_result(keycode_type k);
      result_type r;
      r = '{kind: KIND_KEY, codepoint: '0, claim_len: '0, raw_bytes: '0,
            key_code: k};
      return r;
   endfunction

   function automatic logic [20:0] decode(logic [2:0] len, logic [31:0] c);
      logic [20:0] cp;
      case (len)
         3'd2:    cp = {10'd0, c[4:0], c[13:8]};
         3'd3:    cp = {5'd0, c[3:0], c[13:8], c[21:16]};
         3'd4:    cp = {c[2:0], c[13:8], c[21:16], c[29:24]};
         default: cp = REPLACEMENT;
      endcase
      return cp;
   endfunction

   localparam state_type IDLE_STATE = '{mode: MODE_IDLE, remaining: '0,
                                        exp_len: '0, collected: '0};

   logic        gap;
   logic        bad_cont;
   logic [2:0]  pos;
   logic [1:0]  rem_dec;
   logic [31:0] col_new;
   result_type  esc_res;

   assign gap     = (cmd == CMD_GAP);
   assign esc_res = char_result({13'd0, ESC_BYTE}, 3'd1, {24'd0, ESC_BYTE});
   assign pos     = state_ff.exp_len - {1'b0, state_ff.remaining};
   assign rem_dec = state_ff.remaining - 2'd1;

   // continuation byte shape check plus guards on the collecting state
   assign bad_cont = (data_byte[7:6] != 2'b10) || (state_ff.exp_len < 3'd2) ||
                     (state_ff.exp_len > 3'd4) || (state_ff.remaining == 2'd0) ||
                     ({1'b0, state_ff.remaining} >= state_ff.exp_len);

   always_comb begin
      case (pos[1:0])
         2'd1:    col_new = state_ff.collected | {16'd0, data_byte, 8'd0};
         2'd2:    col_new = state_ff.collected | {8'd0, data_byte, 16'd0};
         2'd3:    col_new = state_ff.collected | {data_byte, 24'd0};
         default: col_new = state_ff.collected;
      endcase
   end

   always_comb begin
      nxt    = IDLE_STATE;
      emit   = 1'b0;
      result = char_result('0, '0, '0);
      case (state_ff.mode)
         MODE_UTF8: begin
            if (gap || bad_cont) begin
               emit   = 1'b1;
               result = char_result(REPLACEMENT, state_ff.exp_len, state_ff.collected);
            end else if (rem_dec == 2'd0) begin
               emit   = 1'b1;
               result = char_result(decode(state_ff.exp_len, col_new),
                                    state_ff.exp_len, col_new);
            end else begin
               nxt           = state_ff;
               nxt.collected = col_new;
               nxt.remaining = rem_dec;
            end
         end
         MODE_ESC: begin
            if (!gap && data_byte == CSI_BYTE) begin
               nxt.mode = MODE_CSI;
            end else if (!gap && data_byte == SS3_BYTE) begin
               nxt.mode = MODE_SS3;
            end else begin
               emit   = 1'b1;
               result = esc_res;
            end
         end
         MODE_CSI: begin
            emit = 1'b1;
            if (gap) begin
               result = esc_res;
            end else begin
               case (data_byte)
                  CH_A:    result = key_result(KEY_UP);
                  CH_B:    result = key_result(KEY_DOWN);
                  CH_C:    result = key_result(KEY_RIGHT);
                  CH_D:    result = key_result(KEY_LEFT);
                  CH_H:    result = key_result(KEY_HOME);
                  CH_F:    result = key_result(KEY_END);
                  CH_3: begin
                     emit     = 1'b0;
                     nxt.mode = MODE_CSI3;
                  end
                  default: result = esc_res;
               endcase
            end
         end
         MODE_CSI3: begin
            emit   = 1'b1;
            result = (!gap && data_byte == CH_TILDE) ? key_result(KEY_DELETE) : esc_res;
         end
         MODE_SS3: begin
            emit = 1'b1;
            if (!gap && data_byte == CH_H) begin
               result = key_result(KEY_HOME);
            end else if (!gap && data_byte == CH_F) begin
               result = key_result(KEY_END);
            end else begin
               result = esc_res;
            end
         end
         default: begin
            if (gap) begin
               emit   = 1'b1;
               result = '{kind: KIND_TIMEOUT, codepoint: '0, claim_len: '0,
                          raw_bytes: '0, key_code: KEY_UP};
            end else if (data_byte == ESC_BYTE) begin
               nxt.mode = MODE_ESC;
            end else if (data_byte[7] == 1'b0) begin
               emit   = 1'b1;
               result = char_result({13'd0, data_byte}, 3'd1, {24'd0, data_byte});
            end else if (data_byte[7:5] == 3'b110 || data_byte[7:4] == 4'b1110 ||
                         data_byte[7:3] == 5'b11110) begin
               nxt.mode      = MODE_UTF8;
               nxt.collected = {24'd0, data_byte};
               if (data_byte[7:5] == 3'b110) begin
                  nxt.exp_len   = 3'd2;
                  nxt.remaining = 2'd1;
               end else if (data_byte[7:4] == 4'b1110) begin
                  nxt.exp_len   = 3'd3;
                  nxt.remaining = 2'd2;
               end else begin
                  nxt.exp_len   = 3'd4;
                  nxt.remaining = 2'd3;
               end
            end else begin
               // stray continuation or 0xF8 and up
               emit   = 1'b1;
               result = char_result(REPLACEMENT, 3'd1, {24'd0, data_byte});
            end
         end
      endcase
   end

   assign state_in = accept ? nxt : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE_STATE;
      end else begin
         state_ff <= state_in;
      end
   end

   `UEK_ASSERT_NOW(a_utf8_counts, clock, reset, state_ff.mode == MODE_UTF8,
      state_ff.exp_len >= 3'd2 && state_ff.exp_len <= 3'd4 &&
      state_ff.remaining != 2'd0 && {1'b0, state_ff.remaining} < state_ff.exp_len)
   `UEK_ASSERT_NOW(a_clear_outside_utf8, clock, reset, state_ff.mode != MODE_UTF8,
      state_ff.remaining == 2'd0 && state_ff.exp_len == 3'd0 && state_ff.collected == 32'd0)

endmodule

`default_nettype wire

// ----- hw/rtl/utf8ek_out.sv -----
// Response register: holds one result word until the sink takes it.
// Depends on utf8ek_pkg, utf8ek_if and the assertion macro header.
`default_nettype none
`include "utf8_and_escape_key_decoder_defines.svh"

module utf8ek_out import utf8ek_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        load,
   input  wire result_type  result,
   output logic             space,
   utf8ek_rsp_if.source     rsp_if
);

   logic       valid_ff, valid_in;
   result_type res_ff, res_in;

   // a word may enter whenever the register is empty or being drained
   assign space = !valid_ff || rsp_if.ready;

   always_comb begin
      valid_in = valid_ff;
      res_in   = res_ff;
      if (load) begin
         valid_in = 1'b1;
         res_in   = result;
      end else if (rsp_if.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign rsp_if.valid      = valid_ff;
   assign rsp_if.kind       = res_ff.kind;
   assign rsp_if.codepoint  = res_ff.codepoint;
   assign rsp_if.claim_len  = res_ff.claim_len;
   assign rsp_if.raw_bytes  = res_ff.raw_bytes;
   assign rsp_if.key_code   = res_ff.key_code;

   `UEK_ASSERT_NEXT(a_load_shows, clock, reset, load, valid_ff)
   `UEK_ASSERT_NOW(a_key_clean, clock, reset, valid_ff && res_ff.kind != KIND_CHAR,
      res_ff.codepoint == 21'd0 && res_ff.claim_len == 3'd0 && res_ff.raw_bytes == 32'd0)

endmodule

`default_nettype wire

// ----- hw/rtl/utf8_and_escape_key_decoder.sv -----
// Top level of the terminal input decoder: UTF-8 characters and escape keys.
// Depends on utf8ek_pkg, utf8ek_if, utf8ek_parse and utf8ek_out.
//
//   channel | dir | fields                                         | handshake
//   req_if  | in  | cmd, data_byte                                 | valid/ready
//   rsp_if  | out | kind, codepoint, claim_len, raw_bytes, key_code | valid/ready
//
// One word is taken per cycle while req_if.ready is high; its result, if any, is shown the cycle after.
// The parser state and the response register are the only storage.
// req_if.ready drops only while a response waits and the sink is stalled.
// Synchronous reset returns the parser to idle and empties the response register.
`default_nettype none

module utf8_and_escape_key_decoder import utf8ek_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   utf8ek_req_if.sink   req_if,
   utf8ek_rsp_if.source rsp_if
);

   logic       accept;
   logic       emit;
   logic       space;
   result_type result;

   assign req_if.ready = space;
   assign accept       = req_if.valid && space;

   utf8ek_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .cmd       (req_if.cmd),
      .data_byte (req_if.data_byte),
      .emit      (emit),
      .result    (result)
   );

   utf8ek_out u_out (
      .clock  (clock),
      .reset  (reset),
      .load   (accept && emit),
      .result (result),
      .space  (space),
      .rsp_if (rsp_if)
   );

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Testbench for the UTF-8 / escape key decoder: directed and random byte streams.
// Uses utf8ek_pkg, the utf8ek_if channel interfaces and utf8_and_escape_key_decoder.
// Expected words come from a behavioural decoder kept in step with the DUT.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import utf8ek_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int MAX_REPORTS = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   reset_done = 1'b0;

   int cycle_count = 0;
   int words_sent  = 0;
   int mismatches  = 0;
   int src_idle_max = 16;
   int snk_idle_max = 16;

   state_type  decoder_state;
   result_type decoded_queue[$];

   utf8ek_req_if req_if();
   utf8ek_rsp_if rsp_if();

   utf8_and_escape_key_decoder u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
                  decoded_queue.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------- decoder

   function automatic result_type char_result(input logic [20:0] cp, input logic [2:0] cnt,
                                              input logic [31:0] raw);
      result_type r;
      r            = '0;
      r.kind       = KIND_CHAR;
      r.codepoint  = cp;
      r.claim_len  = cnt;
      r.raw_bytes  = raw;
      r.key_code   = KEY_UP;
      return r;
   endfunction

   function automatic result_type key_result(input keycode_type k);
      result_type r;
      r          = '0;
      r.kind     = KIND_KEY;
      r.key_code = k;
      return r;
   endfunction

   function automatic result_type escape_char();
      return char_result({13'd0, ESC_BYTE}, 3'd1, {24'd0, ESC_BYTE});
   endfunction

   // Advances the decoder by one word; returns 1 when a result word is due.
   function automatic bit decode_word(input logic gap, input logic [7:0] b,
                                      output result_type r);
      logic [2:0]  pos;
      logic [2:0]  len;
      logic [20:0] cp;
      logic [31:0] raw;
      r = '0;
      case (decoder_state.mode)
         MODE_UTF8: begin
            if (gap || b[7:6] != 2'b10) begin
               r = char_result(REPLACEMENT, decoder_state.exp_len, decoder_state.collected);
               decoder_state = '0;
               return 1'b1;
            end
            pos = decoder_state.exp_len - {1'b0, decoder_state.remaining};
            decoder_state.collected = decoder_state.collected | ({24'd0, b} << (8 * pos));
            decoder_state.remaining = decoder_state.remaining - 2'd1;
            if (decoder_state.remaining != 2'd0)
               return 1'b0;
            raw = decoder_state.collected;
            case (decoder_state.exp_len)
               3'd2:    cp = {10'd0, raw[4:0], raw[13:8]};
               3'd3:    cp = {5'd0, raw[3:0], raw[13:8], raw[21:16]};
               default: cp = {raw[2:0], raw[13:8], raw[21:16], raw[29:24]};
            endcase
            r = char_result(cp, decoder_state.exp_len, raw);
            decoder_state = '0;
            return 1'b1;
         end
         MODE_ESC: begin
            if (!gap && b == CSI_BYTE) begin
               decoder_state.mode = MODE_CSI;
               return 1'b0;
            end
            if (!gap && b == SS3_BYTE) begin
               decoder_state.mode = MODE_SS3;
               return 1'b0;
            end
            r = escape_char();
         end
         MODE_CSI: begin
            if (gap)
               r = escape_char();
            else begin
               case (b)
                  CH_A:    r = key_result(KEY_UP);
                  CH_B:    r = key_result(KEY_DOWN);
                  CH_C:    r = key_result(KEY_RIGHT);
                  CH_D:    r = key_result(KEY_LEFT);
                  CH_H:    r = key_result(KEY_HOME);
                  CH_F:    r = key_result(KEY_END);
                  CH_3: begin
                     decoder_state.mode = MODE_CSI3;
                     return 1'b0;
                  end
                  default: r = escape_char();
               endcase
            end
         end
         MODE_CSI3: begin
            if (!gap && b == CH_TILDE)
               r = key_result(KEY_DELETE);
            else
               r = escape_char();
         end
         MODE_SS3: begin
            if (!gap && b == CH_H)
               r = key_result(KEY_HOME);
            else if (!gap && b == CH_F)
               r = key_result(KEY_END);
            else
               r = escape_char();
         end
         default: begin
            decoder_state = '0;
            if (gap) begin
               r      = '0;
               r.kind = KIND_TIMEOUT;
               return 1'b1;
            end
            if (b == ESC_BYTE) begin
               decoder_state.mode = MODE_ESC;
               return 1'b0;
            end
            if (b[7] == 1'b0) begin
               r = char_result({13'd0, b}, 3'd1, {24'd0, b});
               return 1'b1;
            end
            if (b[7:5] == 3'b110)
               len = 3'd2;
            else if (b[7:4] == 4'b1110)
               len = 3'd3;
            else if (b[7:3] == 5'b11110)
               len = 3'd4;
            else begin
               r = char_result(REPLACEMENT, 3'd1, {24'd0, b});
               return 1'b1;
            end
            decoder_state.mode      = MODE_UTF8;
            decoder_state.exp_len   = len;
            decoder_state.remaining = 2'(len - 3'd1);
            decoder_state.collected = {24'd0, b};
            return 1'b0;
         end
      endcase
      // every branch that falls through here has ended the sequence
      decoder_state = '0;
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------- drivers

   function automatic int wait_cycles(input int max);
      if (max == 0 || $urandom_range(0, 1) == 0)
         return 0;
      return $urandom_range(1, max);
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_word(input logic cmd, input logic [7:0] b);
      int         idle;
      result_type r;
      idle = wait_cycles(src_idle_max);
      if (idle != 0) begin
         req_if.valid = 1'b0;
         repeat (idle) @(negedge clock);
      end
      req_if.valid     = 1'b1;
      req_if.cmd       = cmd;
      req_if.data_byte = b;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      if (decode_word(cmd == CMD_GAP, b, r))
         decoded_queue.push_back(r);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_word(CMD_BYTE, b);
   endtask

   // data_byte carries junk on a gap; the DUT must ignore it
   task automatic send_gap();
      send_word(CMD_GAP, 8'($urandom));
   endtask

   task automatic wait_for_results();
      req_if.valid = 1'b0;
      while (decoded_queue.size() != 0)
         @(negedge clock);
   endtask

   task automatic send_noise();
      if ($urandom_range(0, 3) == 0)
         send_gap();
      else
         send_byte(8'($urandom_range(0, 255)));
   endtask

   function automatic logic [7:0] lead_byte(input int len);
      case (len)
         2:       return 8'($urandom_range(8'hC0, 8'hDF));
         3:       return 8'($urandom_range(8'hE0, 8'hEF));
         default: return 8'($urandom_range(8'hF0, 8'hF7));
      endcase
   endfunction

   function automatic logic [7:0] cont_byte();
      return 8'($urandom_range(8'h80, 8'hBF));
   endfunction

   task automatic send_escape_key(input int which);
      logic [7:0] csi_final[6];
      csi_final = '{CH_A, CH_B, CH_C, CH_D, CH_H, CH_F};
      send_byte(ESC_BYTE);
      if (which < 6) begin
         send_byte(CSI_BYTE);
         send_byte(csi_final[which]);
      end else if (which == 6) begin
         send_byte(CSI_BYTE);
         send_byte(CH_3);
         send_byte(CH_TILDE);
      end else begin
         send_byte(SS3_BYTE);
         send_byte(which == 7 ? CH_H : CH_F);
      end
   endtask

   task automatic send_random_sequence();
      int pick;
      int len;
      int depth;
      pick = $urandom_range(0, 99);
      if (pick < 25)
         send_byte(8'($urandom_range(0, 127)));
      else if (pick < 50) begin
         len = $urandom_range(2, 4);
         send_byte(lead_byte(len));
         repeat (len - 1) send_byte(cont_byte());
      end else if (pick < 72)
         send_escape_key($urandom_range(0, 8));
      else if (pick < 80) begin
         // escape prefix cut short at a random depth
         depth = $urandom_range(0, 3);
         send_byte(ESC_BYTE);
         if (depth == 1 || depth == 2) send_byte(CSI_BYTE);
         if (depth == 2) send_byte(CH_3);
         if (depth == 3) send_byte(SS3_BYTE);
         send_noise();
      end else if (pick < 88) begin
         len = $urandom_range(2, 4);
         send_byte(lead_byte(len));
         repeat ($urandom_range(0, len - 2)) send_byte(cont_byte());
         send_noise();
      end else
         send_noise();
   endtask

   // ---------------------------------------------------------------- checker

   task automatic check_result();
      result_type got;
      result_type want;
      got.kind       = kind_type'(rsp_if.kind);
      got.codepoint  = rsp_if.codepoint;
      got.claim_len  = rsp_if.claim_len;
      got.raw_bytes  = rsp_if.raw_bytes;
      got.key_code   = keycode_type'(rsp_if.key_code);
      if (decoded_queue.size() == 0) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("unexpected word at cycle %0d: kind %0d cp %h cnt %0d raw %h key %0d",
                     cycle_count, got.kind, got.codepoint, got.claim_len, got.raw_bytes,
                     got.key_code);
         return;
      end
      want = decoded_queue.pop_front();
      if (got.kind !== want.kind || got.codepoint !== want.codepoint ||
          got.claim_len !== want.claim_len || got.raw_bytes !== want.raw_bytes ||
          got.key_code !== want.key_code) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("mismatch at cycle %0d: expected kind %0d cp %h cnt %0d raw %h key %0d, %s",
                     cycle_count, want.kind, want.codepoint, want.claim_len, want.raw_bytes,
                     want.key_code, $sformatf("got kind %0d cp %h cnt %0d raw %h key %0d",
                     got.kind, got.codepoint, got.claim_len, got.raw_bytes, got.key_code));
      end
   endtask

   initial begin : rsp_sink
      int stall;
      rsp_if.ready = 1'b0;
      wait (reset_done);
      forever begin
         stall = wait_cycles(snk_idle_max);
         if (stall != 0) begin
            rsp_if.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_if.ready = 1'b1;
         do @(posedge clock); while (rsp_if.valid !== 1'b1);
         check_result();
         @(negedge clock);
      end
   end

   // ---------------------------------------------------------------- tests

   task automatic test_utf8_directed();
      send_byte(8'h00);
      send_byte(8'h7F);
      send_byte(8'hC2); send_byte(8'h80);
      // largest 4-byte form: 0x1FFFFF, no range check
      send_byte(8'hF7); send_byte(8'hBF); send_byte(8'hBF); send_byte(8'hBF);
      send_byte(8'h80);                   // stray continuation as lead
      send_byte(8'hFF);
      send_byte(8'hE2); send_byte(8'h41); // bad continuation, 'A' swallowed
      send_byte(8'hC3); send_gap();       // gap mid-character
      send_gap();                         // gap while idle
   endtask

   task automatic test_escape_directed();
      send_escape_key(0);
      send_escape_key(6);
      send_escape_key(8);
      send_byte(ESC_BYTE); send_gap();
   endtask

   task automatic test_random_stream(input int count, input int src_max, input int snk_max);
      int stop_at;
      src_idle_max = src_max;
      snk_idle_max = snk_max;
      stop_at = words_sent + count;
      while (words_sent < stop_at)
         send_random_sequence();
   endtask

   initial begin : main
      decoder_state    = '0;
      req_if.valid     = 1'b0;
      req_if.cmd       = CMD_BYTE;
      req_if.data_byte = 8'h00;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset      = 1'b0;
      reset_done = 1'b1;

      test_utf8_directed();
      test_escape_directed();
      test_random_stream(450, 16, 16);
      wait_for_results();
      test_random_stream(250, 0, 0);
      test_random_stream(150, 16, 0);
      test_random_stream(150, 0, 16);

      wait_for_results();
      repeat (8) @(negedge clock);
      if (mismatches == 0 && decoded_queue.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
